[hdl/spq_pkg.sv]
package spq_pkg;

    // Queue depth; position and occupancy widths below are sized for it
    localparam int QUEUE_DEPTH = 16;

    // Fixed field widths
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int OCC_W    = 5;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // load the input item registers
        logic execute;   // carry out the held operation, load the result
    } t_dp_cmd;

endpackage

[hdl/sorted_priority_queue.sv]
// Sorted priority queue of (key, id) entries, smallest key at the head.
//
// Input channel (s_axis): one item per operation. tuser carries the opcode
// (insert, pop head, read at position); tdata carries key, id and position.
// Output channel (m_axis): exactly one result item per input item, in order.
// tuser carries the status (ok, not found, full); tdata carries the id and
// key of a popped or read entry (zero otherwise) and the occupancy after
// the operation.
//
// Operation: the input item is registered, then the whole cell row compares
// against the new key and shifts while the result register is loaded.
// Throughput: one item per cycle while results are taken; a new item is
// accepted in the same cycle the previous one executes.
//
// Output stall: a waiting result holds; the held input item waits in its
// register until the result register frees, and ready drops meanwhile.
// Reset (i_rst_n low, synchronous): queue empty, no result pending. Entry
// contents are not cleared; only slots below the occupancy are ever read.
module sorted_priority_queue #(
    parameter int KEY_BITS    = 32,
    parameter int ID_BITS     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // tdata: sort_key, entry_id, position (from bit 0 up), zero padded
    input  logic [((KEY_BITS + ID_BITS + spq_pkg::POS_W + 7) / 8) * 8 - 1:0]
                 i_s_axis_tdata,
    // tuser: opcode
    input  logic [spq_pkg::OPCODE_W-1:0] i_s_axis_tuser,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata: out_entry_id, out_key, occupancy (from bit 0 up), zero padded
    output logic [((KEY_BITS + ID_BITS + spq_pkg::OCC_W + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata,
    // tuser: status
    output logic [spq_pkg::STATUS_W-1:0] o_m_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready
);
    import spq_pkg::*;

    localparam int OUT_TDATA_W = ((KEY_BITS + ID_BITS + OCC_W + 7) / 8) * 8;
    localparam int OCC_LSB     = ID_BITS + KEY_BITS;

    t_dp_cmd             cmd;
    logic [ID_BITS-1:0]  res_id;
    logic [KEY_BITS-1:0] res_key;
    logic [OCC_W-1:0]    res_occ;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .KEY_BITS    (KEY_BITS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_s_axis_tuser),
        .i_sort_key  (i_s_axis_tdata[KEY_BITS-1:0]),
        .i_entry_id  (i_s_axis_tdata[KEY_BITS+ID_BITS-1:KEY_BITS]),
        .i_position  (i_s_axis_tdata[KEY_BITS+ID_BITS+POS_W-1:KEY_BITS+ID_BITS]),
        .o_status    (o_m_axis_tuser),
        .o_entry_id  (res_id),
        .o_key       (res_key),
        .o_occupancy (res_occ)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({res_occ, res_key, res_id});

    // Result register is only loaded when it is free
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.execute |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwritten while held");

    // An accepted item executes next cycle unless a result is still held
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (cmd.execute || o_m_axis_tvalid))
        else $error("accepted item neither executed nor waiting");

    // Full status only reported with a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL))
        |-> (o_m_axis_tdata[OCC_LSB+OCC_W-1:OCC_LSB] == OCC_W'(QUEUE_DEPTH)))
        else $error("full status with spare room");

    // A finished operation yields a valid result on the following cycle
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.execute |=> o_m_axis_tvalid)
        else $error("executed operation lost its result");

endmodule

[hdl/spq_ctrl.sv]
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spq_pkg::t_dp_cmd  o_cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   res_free;

    // Result register may be loaded when empty or being emptied this cycle
    assign res_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.execute = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = res_free;
                o_in_ready    = res_free;
                if (res_free && !i_in_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.capture = i_in_valid && o_in_ready;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/spq_datapath.sv]
module spq_datapath #(
    parameter int KEY_BITS    = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spq_pkg::t_dp_cmd              i_cmd,
    input  logic [spq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [KEY_BITS-1:0]           i_sort_key,
    input  logic [ID_BITS-1:0]            i_entry_id,
    input  logic [spq_pkg::POS_W-1:0]     i_position,
    output logic [spq_pkg::STATUS_W-1:0]  o_status,
    output logic [ID_BITS-1:0]            o_entry_id,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [spq_pkg::OCC_W-1:0]     o_occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Held input item
    logic [OPCODE_W-1:0] r_op;
    logic [KEY_BITS-1:0] r_key_in;
    logic [ID_BITS-1:0]  r_id_in;
    logic [POS_W-1:0]    r_pos;

    // Entry cells, slot 0 is the head
    logic [KEY_BITS-1:0] r_keys [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  r_ids  [QUEUE_DEPTH];
    logic [CNT_W-1:0]    r_count, n_count;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_BITS-1:0]  r_res_id, n_res_id;
    logic [KEY_BITS-1:0] r_res_key, n_res_key;
    logic [OCC_W-1:0]    r_occ;

    logic                full, empty, hit;
    logic                do_ins, do_pop;
    logic [QUEUE_DEPTH-1:0] place;
    logic [KEY_BITS-1:0] rd_key;
    logic [ID_BITS-1:0]  rd_id;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_key_in <= i_sort_key;
            r_id_in  <= i_entry_id;
            r_pos    <= i_position;
        end
    end

    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);
    assign hit    = (32'(r_pos) < 32'(r_count));
    assign do_ins = i_cmd.execute && (r_op == OP_INSERT) && !full;
    assign do_pop = i_cmd.execute && (r_op == OP_POP) && !empty;

    // Per-cell compare: the new entry goes into the first slot whose key is
    // >= the new key, ahead of equal keys, or at the tail when none is
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            place[i] = ((32'(i) < 32'(r_count)) && (r_key_in <= r_keys[i]))
                       || (32'(i) == 32'(r_count));
        end
    end

    // Read-at-index select
    always_comb begin
        rd_key = '0;
        rd_id  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (32'(i) == 32'(r_pos)) begin
                rd_key = r_keys[i];
                rd_id  = r_ids[i];
            end
        end
    end

    genvar g;
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                lo_place;
        logic [KEY_BITS-1:0] lo_key, hi_key;
        logic [ID_BITS-1:0]  lo_id, hi_id;

        if (g == 0) begin : g_head
            assign lo_place = 1'b0;
            assign lo_key   = r_key_in;
            assign lo_id    = r_id_in;
        end else begin : g_body
            assign lo_place = place[g-1];
            assign lo_key   = r_keys[g-1];
            assign lo_id    = r_ids[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign hi_key = r_keys[g];
            assign hi_id  = r_ids[g];
        end else begin : g_inner
            assign hi_key = r_keys[g+1];
            assign hi_id  = r_ids[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_ins) begin
                if (lo_place) begin
                    r_keys[g] <= lo_key;
                    r_ids[g]  <= lo_id;
                end else if (place[g]) begin
                    r_keys[g] <= r_key_in;
                    r_ids[g]  <= r_id_in;
                end
            end else if (do_pop) begin
                r_keys[g] <= hi_key;
                r_ids[g]  <= hi_id;
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_NOT_FOUND;
        n_res_id  = '0;
        n_res_key = '0;
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (!empty) begin
                    n_status  = ST_OK;
                    n_res_id  = r_ids[0];
                    n_res_key = r_keys[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (hit) begin
                    n_status  = ST_OK;
                    n_res_id  = rd_id;
                    n_res_key = rd_key;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status  <= n_status;
            r_res_id  <= n_res_id;
            r_res_key <= n_res_key;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_status    = r_status;
    assign o_entry_id  = r_res_id;
    assign o_key       = r_res_key;
    assign o_occupancy = r_occ;

endmodule
